// ----- rtl/lbc_pkg.sv -----
// Package: shared types, codes and constants of the LED blink controller.
`default_nettype none
package lbc_pkg;

  localparam int unsigned TPS_W    = 10;
  localparam int unsigned FLASH_W  = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COLOR_W  = 3;
  localparam int unsigned SPEED_W  = 4;
  localparam int unsigned DRIVE_W  = 2;
  localparam int unsigned HALVES_W = 5;
  localparam int unsigned CNT_W    = $clog2(TPS_W + 1);

  localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(100);
  localparam logic [FLASH_W-1:0] FLASH_RESET = FLASH_W'(4);
  localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(9);
  localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_TEMP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [DRIVE_W-1:0] COLOR_OFF   = 2'd0;
  localparam logic [DRIVE_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_UNDEF = 3'd4;

  typedef enum logic [0:0] {
    REG_TPS    = 1'b0,
    REG_FLASH  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [TPS_W-1:0]   dividend;
    logic [SPEED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TPS_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/led_blink_controller.sv -----
// Top level: LED blink controller, command decode, blink state and result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, mode, color, speed    | to block
//  out     | out_valid, out_ready, drive_color,        | from block
//          | drive_changed, blinking, temp_left        |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | to block
//
// No-reload word (counting tick, stop, mode 3): IDLE goes straight to DONE, and the
// output register is loaded from DONE. Reloading word: IDLE, then DIV while the shared
// divider yields one bit of ticks_per_second / rate per cycle, then DONE.
// in_ready is high only in IDLE; a finished word waits in DONE while the output
// register is full. Synchronous rst clears blink state and out_valid and sets
// the registers to 100 ticks/s and 4 flashes; cfg_ready is always high.
`default_nettype none
module led_blink_controller
  import lbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [COLOR_W-1:0] color,
  input  wire logic [SPEED_W-1:0] speed,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DRIVE_W-1:0]      drive_color,
  output logic                    drive_changed,
  output logic                    blinking,
  output logic [HALVES_W-1:0]     temp_left,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [TPS_W-1:0]   cfg_data
);

  // configuration registers
  logic [TPS_W-1:0]    ticks_per_second;
  logic [FLASH_W-1:0]  temp_flashes;

  // blink state
  state_t              state, state_next;
  logic                phase_on, phase_on_next;
  logic [DRIVE_W-1:0]  steady_color, steady_color_next;
  logic [SPEED_W-1:0]  blink_rate, blink_rate_next;
  logic [SPEED_W-1:0]  temp_rate, temp_rate_next;
  logic [DRIVE_W-1:0]  temp_color, temp_color_next;
  logic [HALVES_W-1:0] temp_halves, temp_halves_next;
  logic [TPS_W-1:0]    countdown, countdown_next;
  logic                timer_running, timer_running_next;
  logic [DRIVE_W-1:0]  driven, driven_next;
  logic                changed, changed_next;

  // command decode
  logic                accept;
  logic                defined;
  logic [SPEED_W-1:0]  spd_clamp;
  logic [SPEED_W-1:0]  spd_temp;
  logic [DRIVE_W-1:0]  steady_upd;
  logic                out_load;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  lbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  assign defined   = color < COLOR_UNDEF;
  assign spd_clamp = (speed > SPEED_MAX) ? SPEED_MAX : speed;
  assign spd_temp  = (spd_clamp == '0) ? SPEED_MIN : spd_clamp;
  assign steady_upd = defined ? color[DRIVE_W-1:0] : steady_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      temp_flashes     <= FLASH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_TPS:   ticks_per_second <= cfg_data;
        REG_FLASH: temp_flashes     <= cfg_data[FLASH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase_on      <= 1'b0;
      steady_color  <= COLOR_OFF;
      blink_rate    <= '0;
      temp_rate     <= '0;
      temp_color    <= COLOR_OFF;
      temp_halves   <= '0;
      countdown     <= '0;
      timer_running <= 1'b0;
      driven        <= COLOR_OFF;
      changed       <= 1'b0;
    end else begin
      state         <= state_next;
      phase_on      <= phase_on_next;
      steady_color  <= steady_color_next;
      blink_rate    <= blink_rate_next;
      temp_rate     <= temp_rate_next;
      temp_color    <= temp_color_next;
      temp_halves   <= temp_halves_next;
      countdown     <= countdown_next;
      timer_running <= timer_running_next;
      driven        <= driven_next;
      changed       <= changed_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next         = state;
    phase_on_next      = phase_on;
    steady_color_next  = steady_color;
    blink_rate_next    = blink_rate;
    temp_rate_next     = temp_rate;
    temp_color_next    = temp_color;
    temp_halves_next   = temp_halves;
    countdown_next     = countdown;
    timer_running_next = timer_running;
    driven_next        = driven;
    changed_next       = changed;
    div_req.start      = 1'b0;
    div_req.dividend   = ticks_per_second;
    div_req.divisor    = spd_clamp;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          changed_next = 1'b0;
          state_next   = ST_DONE;
          case (mode_t'(mode))
            MODE_SET: begin
              if (defined) begin
                steady_color_next = color[DRIVE_W-1:0];
                driven_next       = color[DRIVE_W-1:0];
                changed_next      = 1'b1;
              end
              blink_rate_next = spd_clamp;
              if (spd_clamp == '0) begin
                // stop: pending temporary halves are kept
                timer_running_next = 1'b0;
                driven_next        = steady_upd;
                changed_next       = 1'b1;
              end else begin
                timer_running_next = 1'b1;
                div_req.start      = 1'b1;
                div_req.divisor    = spd_clamp;
                state_next         = ST_DIV;
              end
            end
            MODE_TEMP: begin
              temp_rate_next   = spd_temp;
              temp_halves_next = {temp_flashes, 1'b0};
              if (defined) begin
                temp_color_next = color[DRIVE_W-1:0];
              end else if (steady_color == COLOR_OFF) begin
                temp_color_next = COLOR_GREEN;
              end else begin
                temp_color_next = steady_color;
              end
              timer_running_next = 1'b1;
              div_req.start      = 1'b1;
              div_req.divisor    = spd_temp;
              state_next         = ST_DIV;
            end
            MODE_TICK: begin
              if (timer_running) begin
                if (countdown > TPS_W'(1)) begin
                  countdown_next = countdown - TPS_W'(1);
                end else begin
                  phase_on_next = !phase_on;
                  changed_next  = 1'b1;
                  if (temp_halves != '0) begin
                    temp_halves_next = temp_halves - HALVES_W'(1);
                    driven_next      = !phase_on ? temp_color : COLOR_OFF;
                    div_req.start    = 1'b1;
                    div_req.divisor  = temp_rate;
                    state_next       = ST_DIV;
                  end else if (blink_rate != '0) begin
                    driven_next     = !phase_on ? steady_color : COLOR_OFF;
                    div_req.start   = 1'b1;
                    div_req.divisor = blink_rate;
                    state_next      = ST_DIV;
                  end else begin
                    driven_next        = steady_color;
                    timer_running_next = 1'b0;
                    countdown_next     = '0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          countdown_next = div_rsp.quotient;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_color   <= driven;
      drive_changed <= changed;
      blinking      <= timer_running;
      temp_left     <= temp_halves;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lbc_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module lbc_div
  import lbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [SPEED_W-1:0]  rem;
  logic [TPS_W-1:0]    quo;
  logic [SPEED_W-1:0]  dsr;
  logic [SPEED_W:0]    trial;
  logic                fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quo[TPS_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(TPS_W);
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      // a rate of zero divides as one
      dsr <= (req.divisor == '0) ? SPEED_MIN : req.divisor;
    end else if (busy) begin
      rem <= fits ? SPEED_W'(trial - {1'b0, dsr}) : trial[SPEED_W-1:0];
      quo <= {quo[TPS_W-2:0], fits};
    end
  end

  assign rsp.done     = busy && (cnt == CNT_W'(1)) && !req.start;
  assign rsp.quotient = {quo[TPS_W-2:0], fits};

endmodule
`default_nettype wire
